FILE: hw/rtl/epic_pkg.sv
// Shared types, constants and register indexes for the encoder position block.
package epic_pkg;

  localparam int PosW = 48;
  localparam int SpeedW = 40;
  localparam logic [31:0] SpeedZeroTimeoutUs = 32'd200000;
  localparam logic [31:0] SpeedUpdateMinUs = 32'd10000;
  localparam logic [27:0] SpeedScale = 28'd256000000;

  localparam logic [1:0] OpService = 2'd0;
  localparam logic [1:0] OpSetPos = 2'd1;
  localparam logic [1:0] OpClearHist = 2'd2;

  localparam logic [2:0] RegTicksPerStep = 3'd0;
  localparam logic [2:0] RegIndexEnable = 3'd1;
  localparam logic [2:0] RegIndexMinInterval = 3'd2;
  localparam logic [2:0] RegIndexMinSteps = 3'd3;
  localparam logic [2:0] RegCorrEnable = 3'd4;
  localparam logic [2:0] RegExpectedSteps = 3'd5;
  localparam logic [2:0] RegMaxError = 3'd6;
  localparam logic [2:0] RegGain = 3'd7;

  typedef struct packed {
    logic [7:0]  ticks_per_step;
    logic        index_enable;
    logic [31:0] index_min_interval_us;
    logic [30:0] index_min_steps_between;
    logic        correction_enable;
    logic [30:0] expected_steps_between_index;
    logic [30:0] max_error_steps;
    logic [8:0]  correction_gain_q8;
  } cfg_t;

  // Request and answer of the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

FILE: hw/rtl/epic_regs.sv
// APB-style configuration register file.
module epic_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output epic_pkg::cfg_t      cfg
);
  import epic_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx = paddr[4:2];
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      // ticks_per_step 4, gain 256, everything else off
      cfg <= {8'd4, 1'b0, 32'd0, 31'd0, 1'b0, 31'd0, 31'd0, 9'd256};
    end else if (wr) begin
      case (idx)
        RegTicksPerStep:     cfg.ticks_per_step <= pwdata[7:0];
        RegIndexEnable:      cfg.index_enable <= pwdata[0];
        RegIndexMinInterval: cfg.index_min_interval_us <= pwdata;
        RegIndexMinSteps:    cfg.index_min_steps_between <= pwdata[30:0];
        RegCorrEnable:       cfg.correction_enable <= pwdata[0];
        RegExpectedSteps:    cfg.expected_steps_between_index <= pwdata[30:0];
        RegMaxError:         cfg.max_error_steps <= pwdata[30:0];
        RegGain:             cfg.correction_gain_q8 <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegTicksPerStep:     prdata = {24'd0, cfg.ticks_per_step};
      RegIndexEnable:      prdata = {31'd0, cfg.index_enable};
      RegIndexMinInterval: prdata = cfg.index_min_interval_us;
      RegIndexMinSteps:    prdata = {1'b0, cfg.index_min_steps_between};
      RegCorrEnable:       prdata = {31'd0, cfg.correction_enable};
      RegExpectedSteps:    prdata = {1'b0, cfg.expected_steps_between_index};
      RegMaxError:         prdata = {1'b0, cfg.max_error_steps};
      RegGain:             prdata = {23'd0, cfg.correction_gain_q8};
      default:             prdata = '0;
    endcase
  end
endmodule

FILE: hw/rtl/epic_div.sv
// Shared unsigned radix-2 restoring divider, 64 bits, one quotient bit a cycle.
module epic_div (
  input  logic                 clk,
  input  logic                 rst,
  input  epic_pkg::div_req_t   req,
  output epic_pkg::div_rsp_t   rsp
);
  import epic_pkg::*;

  logic        busy;
  logic        done;
  logic [6:0]  cnt;
  logic [63:0] quo;
  logic [64:0] rem;
  logic [63:0] den;
  logic [64:0] trial;
  logic [64:0] sub;

  assign trial = {rem[63:0], quo[63]};
  assign sub = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 7'd64;
        quo <= req.num;
        rem <= '0;
        den <= req.den;
      end else if (busy) begin
        if (!sub[64]) begin
          rem <= sub;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo, rem[63:0]};
endmodule

FILE: hw/rtl/encoder_position_index_correction.sv
// Top level: encoder position tracker with index spacing correction.
// Input channel (in_valid/in_ready) carries one operation item; the output
// channel (out_valid/out_ready) returns exactly one result item per input.
// Configuration registers sit on the APB-style port at byte address 4*i and
// may be written only while the block is idle.
// A service item with nonzero elapsed time runs the shared 64-bit divider
// once for ticks into steps and again for the speed quotient when due. Set
// position, clear history and ignored items go straight to S_DONE. The
// divider sets the rate.
// One item is worked at a time; in_ready is low from acceptance until the
// result has been taken by the receiver. A stalled receiver holds the result
// register and blocks further input.
// Reset (rst, synchronous) clears all tracking state and loads the register
// defaults (ticks_per_step 4, gain 256).
module encoder_position_index_correction (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic signed [15:0]  tick_delta,
  input  logic [31:0]         elapsed_us,
  input  logic [7:0]          index_pending_count,
  input  logic [31:0]         index_time_us,
  input  logic signed [47:0]  new_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [47:0]  position_corrected,
  output logic signed [47:0]  position_raw,
  output logic signed [47:0]  correction_offset,
  output logic signed [39:0]  speed_q8,
  output logic [31:0]         index_pulse_count,
  output logic signed [47:0]  last_index_distance_steps,
  output logic [31:0]         last_index_distance_us,
  output logic signed [47:0]  last_index_error_steps,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import epic_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_STEPDIV, S_STEPWAIT, S_SPEED, S_SPDMUL, S_SPDWAIT,
    S_INDEX, S_CORR, S_DONE
  } state_t;

  cfg_t     cfg;
  div_req_t dreq;
  div_rsp_t drsp;

  epic_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  epic_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  state_t state;

  logic [47:0] raw_position, offset_steps, last_index_position;
  logic [47:0] distance_steps_held, error_steps_held;
  logic signed [8:0] tick_remainder;
  logic signed [31:0] speed_ticks_sum;
  logic [31:0] speed_time_sum, still_time_sum, last_index_time;
  logic [31:0] pulse_total, distance_us_held;
  logic signed [39:0] speed_value;
  logic have_last_index;

  // captured item
  logic signed [15:0] i_delta;
  logic [31:0] i_dt, i_when;
  logic [7:0]  i_count;

  logic [7:0]  tps;
  logic        total_neg;
  logic [31:0] num_reg, den_reg;
  logic        neg_sum;
  logic        corr_pending;

  // corr / error work registers
  logic signed [49:0] err;
  logic [49:0] err_mag;

  assign tps = (cfg.ticks_per_step == 8'd0) ? 8'd1 : cfg.ticks_per_step;
  assign in_ready = (state == S_IDLE) && !out_valid;

  // step division helpers
  logic signed [17:0] tot_sum;
  assign tot_sum = 18'(signed'(tick_remainder)) + 18'(signed'(i_delta));

  // speed sums after this item
  logic signed [32:0] tsum_ext;
  logic signed [31:0] tsum_sat;
  logic [32:0] ttime_ext, still_ext;
  logic [31:0] ttime_sat, still_new;
  assign tsum_ext = 33'(speed_ticks_sum) + 33'(i_delta);
  assign tsum_sat = (tsum_ext > 33'sd2147483647) ? 32'sh7FFFFFFF :
                    (tsum_ext < -33'sd2147483648) ? 32'sh80000000 : tsum_ext[31:0];
  assign ttime_ext = {1'b0, speed_time_sum} + {1'b0, i_dt};
  assign ttime_sat = ttime_ext[32] ? 32'hFFFFFFFF : ttime_ext[31:0];
  assign still_ext = {1'b0, still_time_sum} + {1'b0, i_dt};
  assign still_new = (i_delta != 16'sd0) ? 32'd0 :
                     (still_ext[32] ? 32'hFFFFFFFF : still_ext[31:0]);

  // index terms
  logic [47:0] dpos;
  logic [47:0] dpos_mag;
  logic [31:0] dtime;
  logic        filt_time, filt_steps;
  assign dpos = raw_position - last_index_position;
  assign dpos_mag = dpos[47] ? 48'(-dpos) : dpos;
  assign dtime = i_when - last_index_time;
  assign filt_time = (cfg.index_min_interval_us != 32'd0) && have_last_index &&
                     (dtime < cfg.index_min_interval_us);
  assign filt_steps = (cfg.index_min_steps_between != 31'd0) && have_last_index &&
                      (dpos_mag < {17'd0, cfg.index_min_steps_between});

  logic [8:0]  gain;
  logic [49:0] corr;
  assign gain = (cfg.correction_gain_q8 > 9'd256) ? 9'd256 : cfg.correction_gain_q8;
  assign corr = 50'((err_mag >> 8) * gain) +
                50'(((18'(err_mag[7:0]) * 18'(gain)) + 18'd128) >> 8);

  logic [47:0] err_sat;
  assign err_sat = (err > 50'sh7FFFFFFFFFFF) ? 48'h7FFFFFFFFFFF :
                   (err < -50'sh800000000000) ? 48'h800000000000 : err[47:0];

  logic [63:0] q_sat;
  always_comb begin
    if (neg_sum)
      q_sat = (drsp.quo > 64'h80_0000_0000) ? 64'h80_0000_0000 : drsp.quo;
    else
      q_sat = (drsp.quo > 64'h7F_FFFF_FFFF) ? 64'h7F_FFFF_FFFF : drsp.quo;
  end

  logic [17:0] sq_mag, sr_mag;
  assign sq_mag = drsp.quo[17:0];
  assign sr_mag = drsp.rem[17:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      dreq.start <= 1'b0;
      corr_pending <= 1'b0;
      raw_position <= '0;
      offset_steps <= '0;
      last_index_position <= '0;
      distance_steps_held <= '0;
      error_steps_held <= '0;
      tick_remainder <= '0;
      speed_ticks_sum <= '0;
      speed_time_sum <= '0;
      still_time_sum <= '0;
      last_index_time <= '0;
      pulse_total <= '0;
      distance_us_held <= '0;
      speed_value <= '0;
      have_last_index <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            i_delta <= tick_delta;
            i_dt <= elapsed_us;
            i_when <= index_time_us;
            i_count <= index_pending_count;
            case (operation)
              OpService: state <= (elapsed_us != 32'd0) ? S_STEPDIV : S_DONE;
              OpSetPos: begin
                raw_position <= new_position;
                tick_remainder <= '0;
                offset_steps <= '0;
                speed_value <= '0;
                speed_ticks_sum <= '0;
                speed_time_sum <= '0;
                still_time_sum <= '0;
                have_last_index <= 1'b0;
                last_index_time <= '0;
                last_index_position <= '0;
                distance_us_held <= '0;
                distance_steps_held <= '0;
                error_steps_held <= '0;
                state <= S_DONE;
              end
              OpClearHist: begin
                have_last_index <= 1'b0;
                last_index_time <= '0;
                last_index_position <= '0;
                distance_us_held <= '0;
                distance_steps_held <= '0;
                error_steps_held <= '0;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_STEPDIV: begin
          total_neg <= tot_sum[17];
          state <= S_STEPWAIT;
          dreq.start <= 1'b1;
          dreq.num <= 64'(tot_sum[17] ? 18'(-tot_sum) : 18'(tot_sum));
          dreq.den <= 64'(tps);
        end
        S_STEPWAIT: begin
          if (drsp.done) begin
            if (total_neg) begin
              raw_position <= raw_position - 48'(sq_mag);
              tick_remainder <= 9'(-sr_mag);
            end else begin
              raw_position <= raw_position + 48'(sq_mag);
              tick_remainder <= 9'(sr_mag);
            end
            state <= S_SPEED;
          end
        end
        S_SPEED: begin
          if (still_new >= SpeedZeroTimeoutUs) begin
            speed_value <= '0;
            speed_ticks_sum <= '0;
            speed_time_sum <= '0;
            still_time_sum <= '0;
            state <= S_INDEX;
          end else begin
            still_time_sum <= still_new;
            speed_ticks_sum <= tsum_sat;
            speed_time_sum <= ttime_sat;
            if (ttime_sat >= SpeedUpdateMinUs) begin
              neg_sum <= tsum_sat[31];
              num_reg <= tsum_sat[31] ? 32'(-tsum_sat) : 32'(tsum_sat);
              den_reg <= ttime_sat;
              state <= S_SPDMUL;
            end else begin
              state <= S_INDEX;
            end
          end
        end
        S_SPDMUL: begin
          // scale numerator and denominator, one multiply each
          dreq.start <= 1'b1;
          dreq.num <= {4'd0, {28'd0, num_reg} * {32'd0, SpeedScale}};
          dreq.den <= {24'd0, {8'd0, den_reg} * {32'd0, tps}};
          state <= S_SPDWAIT;
        end
        S_SPDWAIT: begin
          if (drsp.done) begin
            speed_value <= neg_sum ? 40'(-q_sat) : q_sat[39:0];
            speed_ticks_sum <= '0;
            speed_time_sum <= '0;
            state <= S_INDEX;
          end
        end
        S_INDEX: begin
          state <= S_DONE;
          if (cfg.index_enable && i_count != 8'd0 && !filt_time && !filt_steps) begin
            pulse_total <= pulse_total + 32'd1;
            distance_us_held <= have_last_index ? dtime : 32'd0;
            distance_steps_held <= have_last_index ? dpos : 48'd0;
            last_index_time <= i_when;
            last_index_position <= raw_position;
            have_last_index <= 1'b1;
            if (cfg.correction_enable && cfg.expected_steps_between_index != 31'd0 &&
                have_last_index && dtime != 32'd0 && i_count == 8'd1) begin
              if (dpos != 48'd0) begin
                if (!dpos[47])
                  err <= 50'(signed'(dpos)) - 50'(cfg.expected_steps_between_index);
                else
                  err <= 50'(signed'(dpos)) + 50'(cfg.expected_steps_between_index);
                state <= S_CORR;
              end
            end else begin
              error_steps_held <= '0;
            end
          end
        end
        S_CORR: begin
          // err is only registered in S_INDEX, so err_mag cannot come from there; compute here
          error_steps_held <= err_sat;
          err_mag <= err[49] ? 50'(-err) : 50'(err);
          state <= S_DONE;
          neg_sum <= err[49];
          corr_pending <= 1'b1;
        end
        S_DONE: begin
          if (corr_pending) begin
            // apply the pending correction
            corr_pending <= 1'b0;
            if (cfg.max_error_steps == 31'd0 ||
                err_mag <= 50'(cfg.max_error_steps)) begin
              if (neg_sum) offset_steps <= offset_steps + corr[47:0];
              else offset_steps <= offset_steps - corr[47:0];
            end
          end else if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            position_corrected <= raw_position + offset_steps;
            position_raw <= raw_position;
            correction_offset <= offset_steps;
            speed_q8 <= speed_value;
            index_pulse_count <= pulse_total;
            last_index_distance_steps <= distance_steps_held;
            last_index_distance_us <= distance_us_held;
            last_index_error_steps <= error_steps_held;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
